// ===== rtl/mvf_pkg.sv =====
// Package for the majority-vote input filter.
// Holds widths, reset values and register indexes used by every file of the block.
`timescale 1ns / 1ps
`default_nettype none
package mvf_pkg;

  // Default number of filtered inputs
  localparam int NUM_INPUTS_DEF = 4;

  // Register and counter widths
  localparam int PERIOD_W = 16;
  localparam int WLEN_W   = 8;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PERIOD_W;

  // Saturation limit of the per-input high counters
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10;
  localparam logic [WLEN_W-1:0]   WLEN_RST   = 8'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 1'b0,
    CFG_WINDOW_LENGTH = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/majority_vote_input_filter_core.sv =====
// Top level of the majority-vote input filter: input register, configuration
// registers and result register around mvf_sampler and mvf_voter. Uses mvf_pkg.
//
//   channel  signals                               direction  transfer when
//   in       in_valid, in_ready, raw_inputs        input      in_valid && in_ready
//   out      out_valid, out_ready, filtered_inputs,
//            window_done                           output     out_valid && out_ready
//   cfg      cfg_we, cfg_index, cfg_data           input      cfg_we
//
// One tick per cycle while the output is not stalled; a tick is held in the
// input register after its transfer, and its result is loaded into the result
// register once that register is free or draining.
// Filter state updates happen as a tick moves from the input register into the
// result register, through one short stage of counter and compare logic.
// Reset (synchronous, rst high) clears the prescaler, counters, filtered word,
// both pipeline valids and loads the register defaults.
// A stalled output holds its result; the input register still takes a tick
// whenever the result register is free or draining in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module majority_vote_input_filter_core #(
  parameter int NUM_INPUTS = mvf_pkg::NUM_INPUTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [NUM_INPUTS-1:0]          raw_inputs,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [NUM_INPUTS-1:0]               filtered_inputs,
  output logic                                window_done,
  input  wire logic                           cfg_we,
  input  wire logic [mvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mvf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [mvf_pkg::PERIOD_W-1:0] sample_period;
  logic [mvf_pkg::WLEN_W-1:0]   window_length;
  logic                         tick_valid;
  logic [NUM_INPUTS-1:0]        tick_raw;
  logic                         advance;
  logic                         sample;
  logic [NUM_INPUTS-1:0]        filtered_next;
  logic                         done_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= mvf_pkg::PERIOD_RST;
      window_length <= mvf_pkg::WLEN_RST;
    end else if (cfg_we) begin
      unique case (mvf_pkg::cfg_reg_t'(cfg_index))
        mvf_pkg::CFG_SAMPLE_PERIOD: sample_period <= cfg_data[mvf_pkg::PERIOD_W-1:0];
        mvf_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data[mvf_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Move a tick forward when the result register is free or draining
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  // Hold the accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_raw <= raw_inputs;
    end
  end

  mvf_sampler u_sampler (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sample_period (sample_period),
    .sample        (sample)
  );

  mvf_voter #(
    .NUM_INPUTS (NUM_INPUTS)
  ) u_voter (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .raw           (tick_raw),
    .window_length (window_length),
    .filtered_next (filtered_next),
    .done_next     (done_next)
  );

  // Load the result register; drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_inputs <= filtered_next;
      window_done     <= done_next;
    end
  end

  // A window can only close on a sampled tick
  a_done_needs_sample: assert property (@(posedge clk) disable iff (rst)
    done_next |-> sample && advance)
    else $error("window closed without a sample");

  // A tick leaving the input register always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  // An accepted tick is held in the input register
  a_accept_fills_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> tick_valid)
    else $error("accepted tick lost");

  // A reported window closure carries the sample that produced it
  a_done_flag_source: assert property (@(posedge clk) disable iff (rst)
    advance && !sample |=> !window_done)
    else $error("window_done set on a tick without a sample");

endmodule
`default_nettype wire

// ===== rtl/mvf_sampler.sv =====
// Tick prescaler of the majority-vote input filter: raises a sample strobe
// when the incremented tick count exceeds the sample period. Uses mvf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvf_sampler (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic [mvf_pkg::PERIOD_W-1:0] sample_period,
  output logic                              sample
);

  logic [mvf_pkg::PERIOD_W-1:0] prescale_count;
  logic [mvf_pkg::PERIOD_W-1:0] prescale_count_inc;

  // Count the tick with wrap, compare against the period
  always_comb begin
    prescale_count_inc = prescale_count + {{(mvf_pkg::PERIOD_W-1){1'b0}}, 1'b1};
    sample             = advance && (prescale_count_inc > sample_period);
  end

  // Advance the prescaler on every tick transfer, restart after a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else if (advance) begin
      prescale_count <= sample ? '0 : prescale_count_inc;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mvf_voter.sv =====
// Voting core of the majority-vote input filter: per-input high counters,
// window sample index and the filtered word. Uses mvf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvf_voter #(
  parameter int NUM_INPUTS = mvf_pkg::NUM_INPUTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       sample,
  input  wire logic [NUM_INPUTS-1:0]      raw,
  input  wire logic [mvf_pkg::WLEN_W-1:0] window_length,
  output logic [NUM_INPUTS-1:0]           filtered_next,
  output logic                            done_next
);

  logic [mvf_pkg::CNT_W-1:0]  high_counts [NUM_INPUTS];
  logic [mvf_pkg::CNT_W-1:0]  counts_bumped [NUM_INPUTS];
  logic [mvf_pkg::WLEN_W-1:0] sample_index;
  logic [mvf_pkg::WLEN_W-1:0] sample_index_inc;
  logic [mvf_pkg::WLEN_W-1:0] threshold;
  logic [NUM_INPUTS-1:0]      vote_word;
  logic [NUM_INPUTS-1:0]      filtered_bits;

  // Bump counters of high inputs with saturation, then vote on the new counts
  always_comb begin
    sample_index_inc = sample_index + {{(mvf_pkg::WLEN_W-1){1'b0}}, 1'b1};
    threshold        = window_length >> 1;
    for (int k = 0; k < NUM_INPUTS; k++) begin
      if (raw[k] && (high_counts[k] != mvf_pkg::CNT_MAX)) begin
        counts_bumped[k] = high_counts[k] + {{(mvf_pkg::CNT_W-1){1'b0}}, 1'b1};
      end else begin
        counts_bumped[k] = high_counts[k];
      end
      vote_word[k] = (counts_bumped[k] >= threshold);
    end
    done_next     = sample && (sample_index_inc >= window_length);
    filtered_next = done_next ? vote_word : filtered_bits;
  end

  // Update state on a sample; clear counters when the window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      filtered_bits <= '0;
      for (int k = 0; k < NUM_INPUTS; k++) begin
        high_counts[k] <= '0;
      end
    end else if (sample) begin
      if (done_next) begin
        sample_index  <= '0;
        filtered_bits <= vote_word;
        for (int k = 0; k < NUM_INPUTS; k++) begin
          high_counts[k] <= '0;
        end
      end else begin
        sample_index <= sample_index_inc;
        for (int k = 0; k < NUM_INPUTS; k++) begin
          high_counts[k] <= counts_bumped[k];
        end
      end
    end
  end

endmodule
`default_nettype wire
